### rtl/core/bmla_pkg.sv
package bmla_pkg;

   localparam int TIMER_BITS = 32;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 16;
   localparam int FADE_BITS = 10;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEBOUNCE_MS       = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IDLE_TIMEOUT_MS   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BLINK_INTERVAL_MS = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FADE_INTERVAL_MS  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FADE_STEP         = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FADE_PEAK         = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BLINK_TOGGLES     = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FADE_TURNS        = 3'd7;

   localparam logic [15:0] RESET_DEBOUNCE_MS       = 16'd50;
   localparam logic [15:0] RESET_IDLE_TIMEOUT_MS   = 16'd5000;
   localparam logic [15:0] RESET_BLINK_INTERVAL_MS = 16'd250;
   localparam logic [15:0] RESET_FADE_INTERVAL_MS  = 16'd50;
   localparam logic [7:0]  RESET_FADE_STEP         = 8'd5;
   localparam logic [7:0]  RESET_FADE_PEAK         = 8'd150;
   localparam logic [7:0]  RESET_BLINK_TOGGLES     = 8'd6;
   localparam logic [3:0]  RESET_FADE_TURNS        = 4'd2;

   localparam logic [7:0] LEVEL_FULL = 8'd255;
   localparam logic [7:0] LEVEL_DARK = 8'd0;

   typedef enum logic [1:0] {
      MODE_OFF   = 2'd0,
      MODE_BLINK = 2'd1,
      MODE_FADE  = 2'd2
   } mode_type;

   typedef struct packed {
      logic [15:0] debounce_ms;
      logic [15:0] idle_timeout_ms;
      logic [15:0] blink_interval_ms;
      logic [15:0] fade_interval_ms;
      logic [7:0]  fade_step;
      logic [7:0]  fade_peak;
      logic [7:0]  blink_toggles;
      logic [3:0]  fade_turns;
   } cfg_type;

   typedef struct packed {
      logic [7:0] red_level;
      logic [7:0] blue_level;
      mode_type   mode_now;
      logic       pixel_update;
   } result_type;

endpackage

### rtl/core/bmla_csr.sv
module bmla_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [bmla_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bmla_pkg::CSR_DATA_BITS-1:0]  csr_data,
   output bmla_pkg::cfg_type                  cfg
);
   import bmla_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DEBOUNCE_MS:       cfg_in.debounce_ms = csr_data;
            CSR_IDLE_TIMEOUT_MS:   cfg_in.idle_timeout_ms = csr_data;
            CSR_BLINK_INTERVAL_MS: cfg_in.blink_interval_ms = csr_data;
            CSR_FADE_INTERVAL_MS:  cfg_in.fade_interval_ms = csr_data;
            CSR_FADE_STEP:         cfg_in.fade_step = csr_data[7:0];
            CSR_FADE_PEAK:         cfg_in.fade_peak = csr_data[7:0];
            CSR_BLINK_TOGGLES:     cfg_in.blink_toggles = csr_data[7:0];
            CSR_FADE_TURNS:        cfg_in.fade_turns = csr_data[3:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms       <= RESET_DEBOUNCE_MS;
         cfg_ff.idle_timeout_ms   <= RESET_IDLE_TIMEOUT_MS;
         cfg_ff.blink_interval_ms <= RESET_BLINK_INTERVAL_MS;
         cfg_ff.fade_interval_ms  <= RESET_FADE_INTERVAL_MS;
         cfg_ff.fade_step         <= RESET_FADE_STEP;
         cfg_ff.fade_peak         <= RESET_FADE_PEAK;
         cfg_ff.blink_toggles     <= RESET_BLINK_TOGGLES;
         cfg_ff.fade_turns        <= RESET_FADE_TURNS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/core/bmla_core.sv
module bmla_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic                 button_level,
   input  bmla_pkg::cfg_type    cfg,
   output bmla_pkg::result_type result
);
   import bmla_pkg::*;

   logic [TIMER_BITS-1:0] tick_ff, tick_in;
   logic [TIMER_BITS-1:0] raw_change_ff, raw_change_in;
   logic [TIMER_BITS-1:0] activity_ff, activity_in;
   logic [TIMER_BITS-1:0] blink_stamp_ff, blink_stamp_in;
   logic [TIMER_BITS-1:0] fade_stamp_ff, fade_stamp_in;
   logic                  previous_raw_ff, stable_ff, stable_in;
   mode_type              mode_ff, mode_in;
   logic [7:0]            toggle_ff, toggle_in;
   logic                  lit_ff, lit_in;
   logic signed [FADE_BITS-1:0] fade_ff, fade_in;
   logic                  falling_ff, falling_in;
   logic [3:0]            turn_ff, turn_in;
   logic [7:0]            red_ff, red_in;
   logic [7:0]            blue_ff, blue_in;
   logic                  update;

   logic [TIMER_BITS-1:0] since_idle, since_raw, since_blink, since_fade;
   logic signed [FADE_BITS:0] fade_wide, step_wide, peak_wide;

   always_comb begin
      tick_in = tick_ff + 1'b1;
      mode_in = mode_ff;
      red_in = red_ff;
      blue_in = blue_ff;
      update = 1'b0;
      activity_in = activity_ff;
      toggle_in = toggle_ff;
      lit_in = lit_ff;
      blink_stamp_in = blink_stamp_ff;
      fade_in = fade_ff;
      falling_in = falling_ff;
      fade_stamp_in = fade_stamp_ff;
      turn_in = turn_ff;
      stable_in = stable_ff;
      fade_wide = '0;
      step_wide = $signed({3'b000, cfg.fade_step});
      peak_wide = $signed({3'b000, cfg.fade_peak});

      since_idle = tick_in - activity_ff;
      if (mode_ff != MODE_OFF && since_idle > TIMER_BITS'(cfg.idle_timeout_ms)) begin
         mode_in = MODE_OFF;
         red_in = LEVEL_DARK;
         blue_in = LEVEL_DARK;
         update = 1'b1;
      end

      raw_change_in = (button_level != previous_raw_ff) ? tick_in : raw_change_ff;
      since_raw = tick_in - raw_change_in;
      if (since_raw > TIMER_BITS'(cfg.debounce_ms) && button_level != stable_ff) begin
         stable_in = button_level;
         if (!button_level) begin
            unique case (mode_in)
               MODE_OFF: begin
                  mode_in = MODE_BLINK;
                  toggle_in = '0;
                  lit_in = 1'b0;
                  blink_stamp_in = '0;
               end
               MODE_BLINK: begin
                  mode_in = MODE_FADE;
                  fade_in = '0;
                  falling_in = 1'b0;
                  fade_stamp_in = '0;
                  turn_in = '0;
               end
               default: mode_in = MODE_OFF;
            endcase
            red_in = LEVEL_DARK;
            blue_in = LEVEL_DARK;
            activity_in = tick_in;
            update = 1'b1;
         end
      end

      since_blink = tick_in - blink_stamp_in;
      since_fade = tick_in - fade_stamp_in;
      unique case (mode_in)
         MODE_BLINK: begin
            if (toggle_in < cfg.blink_toggles &&
                since_blink >= TIMER_BITS'(cfg.blink_interval_ms)) begin
               blink_stamp_in = tick_in;
               lit_in = !lit_in;
               red_in = lit_in ? LEVEL_FULL : LEVEL_DARK;
               blue_in = LEVEL_DARK;
               update = 1'b1;
               toggle_in = toggle_in + 1'b1;
               activity_in = tick_in;
            end
         end
         MODE_FADE: begin
            if (turn_in < cfg.fade_turns &&
                since_fade >= TIMER_BITS'(cfg.fade_interval_ms)) begin
               fade_stamp_in = tick_in;
               red_in = LEVEL_DARK;
               if (fade_in <= 0) begin
                  blue_in = LEVEL_DARK;
               end else if (fade_in >= $signed({2'b00, LEVEL_FULL})) begin
                  blue_in = LEVEL_FULL;
               end else begin
                  blue_in = fade_in[7:0];
               end
               update = 1'b1;
               if (falling_in) begin
                  fade_wide = {fade_in[FADE_BITS-1], fade_in} - step_wide;
               end else begin
                  fade_wide = {fade_in[FADE_BITS-1], fade_in} + step_wide;
               end
               fade_in = fade_wide[FADE_BITS-1:0];
               if (fade_wide <= 0 || fade_wide >= peak_wide) begin
                  falling_in = !falling_in;
                  turn_in = turn_in + 1'b1;
               end
               activity_in = tick_in;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= '0;
         raw_change_ff <= '0;
         activity_ff <= '0;
         blink_stamp_ff <= '0;
         fade_stamp_ff <= '0;
         previous_raw_ff <= 1'b1;
         stable_ff <= 1'b0;
         mode_ff <= MODE_OFF;
         toggle_ff <= '0;
         lit_ff <= 1'b0;
         fade_ff <= '0;
         falling_ff <= 1'b0;
         turn_ff <= '0;
         red_ff <= '0;
         blue_ff <= '0;
      end else if (step) begin
         tick_ff <= tick_in;
         raw_change_ff <= raw_change_in;
         activity_ff <= activity_in;
         blink_stamp_ff <= blink_stamp_in;
         fade_stamp_ff <= fade_stamp_in;
         previous_raw_ff <= button_level;
         stable_ff <= stable_in;
         mode_ff <= mode_in;
         toggle_ff <= toggle_in;
         lit_ff <= lit_in;
         fade_ff <= fade_in;
         falling_ff <= falling_in;
         turn_ff <= turn_in;
         red_ff <= red_in;
         blue_ff <= blue_in;
      end
   end

   assign result.red_level = red_in;
   assign result.blue_level = blue_in;
   assign result.mode_now = mode_in;
   assign result.pixel_update = update;

endmodule

### rtl/core/button_mode_led_animator_unit.sv
// Each transfer on the request channel is one millisecond tick carrying the raw button
// level (0 pressed); each tick yields exactly one response with the red and blue levels,
// the current mode (0 off, 1 blink, 2 fade) and a flag that is set when the pixel was
// rewritten on that tick. The block takes one tick per clock cycle while responses are
// taken. A taken tick waits in the input register, then one pass through the state
// update loads the response register. The state update loop sets the rate. A response
// that is not taken holds the tick behind it in the input register. The user must write
// registers through the csr_ port only while no tick is in flight; the block itself does
// not enforce this.
module button_mode_led_animator_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_button_level,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [7:0]                         rsp_red_level,
   output logic [7:0]                         rsp_blue_level,
   output logic [1:0]                         rsp_mode_now,
   output logic                               rsp_pixel_update,
   input  logic                               csr_write_enable,
   input  logic [bmla_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bmla_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import bmla_pkg::*;

   cfg_type    cfg;
   result_type result;
   result_type rsp_ff;
   logic       in_valid_ff, in_valid_in;
   logic       in_level_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       step;

   bmla_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .cfg              (cfg)
   );

   bmla_core u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .button_level (in_level_ff),
      .cfg          (cfg),
      .result       (result)
   );

   assign step = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_level_ff <= req_button_level;
      end
      if (step) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red_level = rsp_ff.red_level;
   assign rsp_blue_level = rsp_ff.blue_level;
   assign rsp_mode_now = rsp_ff.mode_now;
   assign rsp_pixel_update = rsp_ff.pixel_update;

endmodule
